### hdl/spp_pkg.sv
// shared constants and helper functions for the symbolic permission parser
package spp_pkg;

   localparam int unsigned DEFAULT_MAX_POSITION = 255;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_O     = 8'h6F;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_W     = 8'h77;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_BIG_X = 8'h58;
   localparam logic [7:0] CHAR_S     = 8'h73;

   // permission bit groups
   localparam logic [8:0]  PERM_READ  = 9'o444;
   localparam logic [8:0]  PERM_WRITE = 9'o222;
   localparam logic [8:0]  PERM_EXEC  = 9'o111;
   localparam logic [8:0]  PERM_RWX   = 9'o777;
   localparam logic [11:0] WHO_USER   = 12'o5700;
   localparam logic [11:0] WHO_GROUP  = 12'o2070;
   localparam logic [11:0] WHO_OTHER  = 12'o0007;
   localparam logic [11:0] WHO_ALL    = 12'o7777;

   // pending operation codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;
   localparam logic [1:0] OP_SET  = 2'd3;

   function automatic logic [1:0] op_code(input logic [7:0] c);
      logic [1:0] op;
      op = OP_NONE;
      if (c == CHAR_PLUS) op = OP_ADD;
      else if (c == CHAR_MINUS) op = OP_SUB;
      else if (c == CHAR_EQUAL) op = OP_SET;
      return op;
   endfunction

   function automatic logic is_perm_letter(input logic [7:0] c);
      return (c == CHAR_R) || (c == CHAR_W) || (c == CHAR_X) ||
             (c == CHAR_BIG_X) || (c == CHAR_S);
   endfunction

   // X and s give no bits
   function automatic logic [8:0] perm_bits(input logic [7:0] c);
      logic [8:0] bits;
      bits = '0;
      if (c == CHAR_R) bits = PERM_READ;
      else if (c == CHAR_W) bits = PERM_WRITE;
      else if (c == CHAR_X) bits = PERM_EXEC;
      return bits;
   endfunction

   function automatic logic [11:0] who_bits(input logic [7:0] c);
      logic [11:0] bits;
      bits = '0;
      if (c == CHAR_U) bits = WHO_USER;
      else if (c == CHAR_G) bits = WHO_GROUP;
      else if (c == CHAR_O) bits = WHO_OTHER;
      else if (c == CHAR_A) bits = WHO_ALL;
      return bits;
   endfunction

   // copy one class's rwx bits to all three classes
   function automatic logic [8:0] copy_bits(input logic [7:0] c, input logic [8:0] mode);
      logic [2:0] b;
      b = mode[2:0];
      if (c == CHAR_U) b = mode[8:6];
      else if (c == CHAR_G) b = mode[5:3];
      return {b, b, b};
   endfunction

   function automatic logic [8:0] apply_op(input logic [1:0] op, input logic [11:0] who,
                                           input logic [8:0] mode, input logic [8:0] bits);
      logic [8:0] b;
      logic [8:0] res;
      b = bits & who[8:0];
      res = mode;
      case (op)
         OP_ADD:  res = mode | b;
         OP_SUB:  res = mode & ~b;
         OP_SET:  res = (mode & ~who[8:0]) | b;
         default: res = mode;
      endcase
      return res;
   endfunction

endpackage

### hdl/symbolic_permission_parser.sv
// symbolic permission expression parser, one character per item
//
// takes a symbolic permission expression (terms [ugoa]*([+-=]([ugo]|[rwxXs]*))*
// joined by commas) one character per item and applies it to a starting
// permission. an item with req_tuser (first) set starts a new expression and
// loads the low nine rwx bits of start_perm. on the first character that fits
// no rule, NUL included, one result item carries the final nine-bit mode, the
// index of that character (saturating at MAX_POSITION) and whether it was NUL;
// items without first are then ignored until the next first item. an empty
// who list means all classes, masked by the current mode unless the op is '='.
// rate: one item per clock while the result side does not stall. each item
// passes an input register, one step of decode and mask logic that also
// updates the parse state, and the result register. a stalled result
// register holds the input register, which in turn drops req_tready.
module symbolic_permission_parser #(
   parameter int unsigned MAX_POSITION = spp_pkg::DEFAULT_MAX_POSITION
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // start_perm[11:0], ch[19:12], zero pad
   input  logic        req_tuser,   // first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // mode[8:0], stop_position[16:9], zero pad
   output logic        rsp_tuser    // stopped_at_end
);

   localparam int unsigned CNT_W = $clog2(MAX_POSITION + 1);

   // parse phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_WHO     = 2'd1;
   localparam logic [1:0] PH_OPSTART = 2'd2;
   localparam logic [1:0] PH_PERMS   = 2'd3;

   // input register
   logic             in_valid_ff, in_valid_in;
   logic             in_first_ff;
   logic [11:0]      in_perm_ff;
   logic [7:0]       in_ch_ff;

   // parse state
   logic [1:0]       phase_ff, phase_in;
   logic [11:0]      who_ff, who_in;
   logic [8:0]       mode_ff, mode_in;
   logic [8:0]       pbits_ff, pbits_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic [8:0]       out_mode_ff;
   logic [7:0]       out_pos_ff;
   logic             out_end_ff;

   logic             advance;
   logic             live;
   logic             emit;
   logic [CNT_W+7:0] cnt_ext;

   // the step only runs when the result register can take whatever it makes
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign live       = in_first_ff || (phase_ff != PH_IDLE);

   // a first item counts from zero
   assign cnt_ext = in_first_ff ? '0 : {8'b0, cnt_ff};

   always_comb begin
      logic [1:0]       ph;
      logic [11:0]      who;
      logic [8:0]       cm;
      logic [8:0]       pb;
      logic [1:0]       op;
      logic [CNT_W-1:0] cnt;
      logic [7:0]       c;
      logic             do_follow;
      logic [8:0]       cm_f;
      logic [11:0]      who_f;
      logic [1:0]       next_op;

      // first item restarts the expression
      ph  = phase_ff;
      who = who_ff;
      cm  = mode_ff;
      pb  = pbits_ff;
      op  = op_ff;
      cnt = cnt_ff;
      if (in_first_ff) begin
         cm  = in_perm_ff[8:0];
         who = '0;
         pb  = '0;
         op  = spp_pkg::OP_NONE;
         cnt = '0;
         ph  = PH_WHO;
      end
      c       = in_ch_ff;
      next_op = spp_pkg::op_code(c);

      phase_in  = ph;
      who_in    = who;
      mode_in   = cm;
      pbits_in  = pb;
      op_in     = op;
      emit      = 1'b0;
      do_follow = 1'b0;
      cm_f      = cm;
      who_f     = who;

      unique case (ph)
         PH_WHO: begin
            if (spp_pkg::who_bits(c) != '0) begin
               who_in = who | spp_pkg::who_bits(c);
            end else begin
               // empty who list means everyone, limited by the mode unless '='
               if (who == '0) begin
                  who_f = (c == spp_pkg::CHAR_EQUAL) ? spp_pkg::WHO_ALL
                                                     : (spp_pkg::WHO_ALL & {3'b0, cm});
               end
               do_follow = 1'b1;
            end
         end
         PH_OPSTART: begin
            if (c == spp_pkg::CHAR_U || c == spp_pkg::CHAR_G || c == spp_pkg::CHAR_O) begin
               mode_in  = spp_pkg::apply_op(op, who, cm, spp_pkg::copy_bits(c, cm));
               op_in    = spp_pkg::OP_NONE;
               pbits_in = '0;
               phase_in = PH_PERMS;
            end else if (spp_pkg::is_perm_letter(c)) begin
               pbits_in = pb | spp_pkg::perm_bits(c);
               phase_in = PH_PERMS;
            end else begin
               cm_f      = spp_pkg::apply_op(op, who, cm, pb);
               do_follow = 1'b1;
            end
         end
         PH_PERMS: begin
            // after a copy letter no op is pending, so rwx letters stop
            if (op != spp_pkg::OP_NONE && spp_pkg::is_perm_letter(c)) begin
               pbits_in = pb | spp_pkg::perm_bits(c);
            end else begin
               cm_f      = spp_pkg::apply_op(op, who, cm, pb);
               do_follow = 1'b1;
            end
         end
         default: begin
            // idle: no live item reaches here
         end
      endcase

      // op, comma or stop after a who list or an action
      if (do_follow) begin
         mode_in  = cm_f;
         who_in   = who_f;
         op_in    = spp_pkg::OP_NONE;
         pbits_in = '0;
         if (next_op != spp_pkg::OP_NONE) begin
            op_in    = next_op;
            phase_in = PH_OPSTART;
         end else if (c == spp_pkg::CHAR_COMMA) begin
            who_in   = '0;
            phase_in = PH_WHO;
         end else begin
            emit     = 1'b1;
            phase_in = PH_IDLE;
         end
      end

      // position count saturates
      cnt_in = cnt;
      if (!emit && (cnt < CNT_W'(MAX_POSITION))) begin
         cnt_in = cnt + CNT_W'(1);
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && live && emit) begin
         out_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         who_ff       <= '0;
         mode_ff      <= '0;
         pbits_ff     <= '0;
         op_ff        <= spp_pkg::OP_NONE;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && live) begin
            phase_ff <= phase_in;
            who_ff   <= who_in;
            mode_ff  <= mode_in;
            pbits_ff <= pbits_in;
            op_ff    <= op_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_first_ff <= req_tuser;
         in_perm_ff  <= req_tdata[11:0];
         in_ch_ff    <= req_tdata[19:12];
      end
      if (advance && live && emit) begin
         out_mode_ff <= mode_in;
         out_pos_ff  <= cnt_ext[7:0];
         out_end_ff  <= (in_ch_ff == spp_pkg::CHAR_NUL);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_pos_ff, out_mode_ff};
   assign rsp_tuser  = out_end_ff;

endmodule

### dv/tb_symbolic_permission_parser.sv
// self-checking testbench for the symbolic permission parser
module tb_symbolic_permission_parser;

   localparam int RANDOM_ITEMS = 1950;
   localparam int LONG_HOLD_CYCLES = 200;   // receiver hold-off that backs up the pipeline
   localparam int DRAIN_CYCLES = 10;        // wait after draining, for a late extra result
   localparam int LIMIT_CYCLES = 600000;

   // parser phases, as the block walks through a term
   typedef enum logic [1:0] {PH_IDLE, PH_WHO, PH_OP_START, PH_PERMS} parse_phase_type;

   // how a directed row is checked
   typedef enum logic [1:0] {FROM_MODEL, NO_RESULT, TYPED_RESULT} row_check_type;

   // shapes of random expressions
   typedef enum logic [1:0] {EXPR_CLEAN, EXPR_BROKEN, EXPR_NOISE, EXPR_LONG} expr_kind_type;

   typedef struct packed {
      logic [8:0] mode;
      logic [7:0] pos;
      logic       at_end;
   } outcome_type;

   typedef struct packed {
      logic          first;
      logic [11:0]   perm;
      logic [7:0]    ch;
      row_check_type check;
      outcome_type   want;
   } stim_row_type;

   localparam logic [7:0] WHO_CHARS [4] = '{spp_pkg::CHAR_U, spp_pkg::CHAR_G,
                                            spp_pkg::CHAR_O, spp_pkg::CHAR_A};
   localparam logic [7:0] OP_CHARS [3] = '{spp_pkg::CHAR_PLUS, spp_pkg::CHAR_MINUS,
                                           spp_pkg::CHAR_EQUAL};
   localparam logic [7:0] RWX_CHARS [5] = '{spp_pkg::CHAR_R, spp_pkg::CHAR_W,
                                            spp_pkg::CHAR_X, spp_pkg::CHAR_BIG_X,
                                            spp_pkg::CHAR_S};

   localparam int N_ROWS = 26;

   // directed items: extremes, idle input, every op, copy letters, empty who,
   // empty action, X and s, and a copy letter after rwx letters
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // ignored right after reset
      '{1'b0, 12'h000, spp_pkg::CHAR_NUL,   NO_RESULT,    '0},
      // empty expression, all start bits set
      '{1'b1, 12'hFFF, spp_pkg::CHAR_NUL,   TYPED_RESULT, '{9'o777, 8'd0, 1'b1}},
      // ignored after a stop
      '{1'b0, 12'hFFF, spp_pkg::CHAR_R,     NO_RESULT,    '0},
      // top byte stops at once, not at end
      '{1'b1, 12'hA5A, 8'hFF,               TYPED_RESULT, '{9'h05A, 8'd0, 1'b0}},
      // u+rwx,g-w,o=u then end of string
      '{1'b1, 12'o0640, spp_pkg::CHAR_U,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_PLUS,  FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_R,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_W,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_X,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_COMMA, FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_G,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_MINUS, FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_W,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_COMMA, FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_O,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_EQUAL, FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_U,     FROM_MODEL, '0},
      '{1'b0, 12'h000, spp_pkg::CHAR_NUL,   FROM_MODEL, '0},
      // +-xs=rX then u: empty who, empty action, copy letter after rwx stops
      '{1'b1, 12'o7755, spp_pkg::CHAR_PLUS,  FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_MINUS, FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_X,     FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_S,     FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_EQUAL, FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_R,     FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_BIG_X, FROM_MODEL, '0},
      '{1'b0, 12'hFFF, spp_pkg::CHAR_U,     FROM_MODEL, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // start_perm[11:0], ch[19:12], zero pad
   logic        req_tuser = 1'b0;  // first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // mode[8:0], stop_position[16:9], zero pad
   logic        rsp_tuser;         // stopped_at_end

   // parser state as predicted
   parse_phase_type ph = PH_IDLE;
   logic [11:0]     who_sel = '0;
   logic [8:0]      cur_mode = '0;
   logic [8:0]      acc_bits = '0;
   logic [1:0]      acc_op = spp_pkg::OP_NONE;
   logic [7:0]      char_pos = '0;

   outcome_type modes_due [$];   // results still to come, oldest first
   logic [7:0]  expr_text [$];   // characters of the expression being sent
   int          error_count = 0;
   int          items_sent = 0;
   bit          req_calm = 1'b0;  // sender offers back to back
   bit          rsp_calm = 1'b0;  // receiver always ready
   bit          long_hold = 1'b0; // asks the receiver for one long stall

   symbolic_permission_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // the closing of an action: bits only reach the classes of the term
   function automatic void apply_pending(input logic [8:0] bits);
      logic [8:0] b;
      b = bits & who_sel[8:0];
      case (acc_op)
         spp_pkg::OP_ADD: cur_mode = cur_mode | b;
         spp_pkg::OP_SUB: cur_mode = cur_mode & ~b;
         spp_pkg::OP_SET: cur_mode = (cur_mode & ~who_sel[8:0]) | b;
         default:         ;
      endcase
      acc_op = spp_pkg::OP_NONE;
      acc_bits = '0;
   endfunction

   function automatic bit rwx_letter(input logic [7:0] ch, output logic [8:0] bits);
      bits = '0;
      case (ch)
         spp_pkg::CHAR_R:                      bits = spp_pkg::PERM_READ;
         spp_pkg::CHAR_W:                      bits = spp_pkg::PERM_WRITE;
         spp_pkg::CHAR_X:                      bits = spp_pkg::PERM_EXEC;
         spp_pkg::CHAR_BIG_X, spp_pkg::CHAR_S: ;   // accepted, no bits
         default:                              return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // what may come after a who list or an action: an op, a comma, or the stop
   function automatic bit follow_char(input logic [7:0] ch, output outcome_type res);
      res = '0;
      if (ch == spp_pkg::CHAR_PLUS || ch == spp_pkg::CHAR_MINUS ||
          ch == spp_pkg::CHAR_EQUAL) begin
         acc_op = (ch == spp_pkg::CHAR_PLUS)  ? spp_pkg::OP_ADD :
                  (ch == spp_pkg::CHAR_MINUS) ? spp_pkg::OP_SUB : spp_pkg::OP_SET;
         acc_bits = '0;
         ph = PH_OP_START;
         return 1'b0;
      end
      if (ch == spp_pkg::CHAR_COMMA) begin
         who_sel = '0;
         ph = PH_WHO;
         return 1'b0;
      end
      res.mode = cur_mode;
      res.pos = char_pos;
      res.at_end = (ch == spp_pkg::CHAR_NUL);
      ph = PH_IDLE;
      return 1'b1;
   endfunction

   // one accepted item; returns 1 when it ends the expression with a result
   function automatic bit parse_char(input logic first, input logic [11:0] perm,
                                     input logic [7:0] ch, output outcome_type res);
      bit         stopped;
      logic [8:0] bits;
      logic [2:0] cls;
      res = '0;
      stopped = 1'b0;
      if (first) begin
         cur_mode = perm[8:0];
         who_sel = '0;
         acc_bits = '0;
         acc_op = spp_pkg::OP_NONE;
         char_pos = '0;
         ph = PH_WHO;
      end else if (ph == PH_IDLE) begin
         return 1'b0;
      end
      case (ph)
         PH_WHO: begin
            if (ch == spp_pkg::CHAR_U) who_sel |= spp_pkg::WHO_USER;
            else if (ch == spp_pkg::CHAR_G) who_sel |= spp_pkg::WHO_GROUP;
            else if (ch == spp_pkg::CHAR_O) who_sel |= spp_pkg::WHO_OTHER;
            else if (ch == spp_pkg::CHAR_A) who_sel |= spp_pkg::WHO_ALL;
            else begin
               // no who letters: all classes, limited to set bits unless '='
               if (who_sel == '0)
                  who_sel = (ch == spp_pkg::CHAR_EQUAL) ? spp_pkg::WHO_ALL
                                                        : (spp_pkg::WHO_ALL &
                                                           {3'b000, cur_mode});
               stopped = follow_char(ch, res);
            end
         end
         PH_OP_START: begin
            if (ch == spp_pkg::CHAR_U || ch == spp_pkg::CHAR_G || ch == spp_pkg::CHAR_O) begin
               // copy one class to all three
               cls = (ch == spp_pkg::CHAR_U) ? cur_mode[8:6] :
                     (ch == spp_pkg::CHAR_G) ? cur_mode[5:3] : cur_mode[2:0];
               apply_pending({cls, cls, cls});
               ph = PH_PERMS;
            end else if (rwx_letter(ch, bits)) begin
               acc_bits |= bits;
               ph = PH_PERMS;
            end else begin
               // empty action applies with no bits
               apply_pending(acc_bits);
               stopped = follow_char(ch, res);
            end
         end
         default: begin
            // after a copy letter no op is pending, so rwx letters end it
            if (acc_op != spp_pkg::OP_NONE && rwx_letter(ch, bits)) begin
               acc_bits |= bits;
            end else begin
               apply_pending(acc_bits);
               stopped = follow_char(ch, res);
            end
         end
      endcase
      if (!stopped && char_pos < spp_pkg::DEFAULT_MAX_POSITION) char_pos++;
      return stopped;
   endfunction

   // builds one random expression into expr_text
   function automatic void make_expression(input expr_kind_type kind);
      int n_terms;
      int t;
      expr_text.delete();
      if (kind == EXPR_NOISE) begin
         repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n_terms = (kind == EXPR_LONG) ? 40 : $urandom_range(1, 4);
      for (t = 0; t < n_terms; t++) begin
         if (t > 0) expr_text.push_back(spp_pkg::CHAR_COMMA);
         repeat ($urandom_range(0, 3)) expr_text.push_back(WHO_CHARS[$urandom_range(0, 3)]);
         repeat ($urandom_range(0, 3)) begin
            expr_text.push_back(OP_CHARS[$urandom_range(0, 2)]);
            if ($urandom_range(0, 4) == 0) begin
               expr_text.push_back(WHO_CHARS[$urandom_range(0, 2)]);
            end else begin
               repeat ($urandom_range(0, 4))
                  expr_text.push_back(RWX_CHARS[$urandom_range(0, 4)]);
               // now and then a copy letter after rwx letters, which stops
               if (kind != EXPR_LONG && $urandom_range(0, 29) == 0)
                  expr_text.push_back(WHO_CHARS[$urandom_range(0, 2)]);
            end
         end
      end
      if (kind == EXPR_BROKEN)
         expr_text.insert($urandom_range(0, expr_text.size()), 8'($urandom_range(0, 255)));
      // mostly end of string, sometimes any byte
      if ($urandom_range(0, 3) == 0) expr_text.push_back(8'($urandom_range(0, 255)));
      else expr_text.push_back(spp_pkg::CHAR_NUL);
   endfunction

   // offers one item, waits for it to be taken, then predicts its result
   task automatic send_item(input logic first, input logic [11:0] perm, input logic [7:0] ch,
                            input row_check_type check, input outcome_type typed);
      int          gap;
      bit          stopped;
      outcome_type got;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, ch, perm};
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      stopped = parse_char(first, perm, ch, got);
      if (check == TYPED_RESULT) modes_due.push_back(typed);
      else if (check == FROM_MODEL && stopped) modes_due.push_back(got);
   endtask

   // result side: random readiness, one long hold-off when asked
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = rsp_calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // every result taken is compared with the oldest prediction
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (modes_due.size() == 0) begin
            flag_mismatch($sformatf("result with none expected, tdata %h tuser %b",
                                    rsp_tdata, rsp_tuser));
         end else begin
            want = modes_due.pop_front();
            if (rsp_tdata[8:0] !== want.mode)
               flag_mismatch($sformatf("mode %o, expected %o", rsp_tdata[8:0], want.mode));
            if (rsp_tdata[16:9] !== want.pos)
               flag_mismatch($sformatf("stop position %0d, expected %0d",
                                       rsp_tdata[16:9], want.pos));
            if (rsp_tuser !== want.at_end)
               flag_mismatch($sformatf("stopped at end %b, expected %b",
                                       rsp_tuser, want.at_end));
         end
      end
   end

   // main stimulus
   initial begin
      int            r;
      int            expr_index;
      expr_kind_type kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_ROWS; i++)
         send_item(DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].perm, DIRECTED_ROWS[i].ch,
                   DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].want);

      // random expressions, mostly well formed
      expr_index = 0;
      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (expr_index == 20 || expr_index == 90) kind = EXPR_LONG;
         else if (r < 75) kind = EXPR_CLEAN;
         else if (r < 87) kind = EXPR_BROKEN;
         else kind = EXPR_NOISE;
         // one long receiver stall while the sender keeps the input busy
         if (expr_index == 5) long_hold = 1'b1;
         req_calm = (expr_index == 5) || ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         make_expression(kind);
         foreach (expr_text[i]) begin
            send_item(i == 0, 12'($urandom_range(0, 4095)), expr_text[i], FROM_MODEL, '0);
            items_sent++;
         end
         // stray items between expressions, normally ignored
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
               send_item(1'b0, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                         FROM_MODEL, '0);
         expr_index++;
      end
      req_tvalid <= 1'b0;

      // drain, then allow for a late extra result
      while (modes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
hdl/spp_pkg.sv
hdl/symbolic_permission_parser.sv
dv/tb_symbolic_permission_parser.sv
